[design/brpc_pkg.sv]
// ----------------------------------------------------------------------------
// brpc_pkg: shared types and constants for the return PC resolver
// Opcodes, status codes and the result record passed between the decode
// logic and the result register.
// ----------------------------------------------------------------------------
package brpc_pkg;

    localparam logic [31:0] BAD_PC   = 32'hDEAD_BEEF;
    localparam logic [31:0] SEG_MASK = 32'hF000_0000;

    // status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNALIGNED = 3'd1;
    localparam logic [2:0] ST_MARKER    = 3'd2;
    localparam logic [2:0] ST_NO_UNIT   = 3'd3;
    localparam logic [2:0] ST_NOT_BR    = 3'd4;

    // major opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_COP1    = 6'd17;
    localparam logic [5:0] OP_BEQL    = 6'd20;
    localparam logic [5:0] OP_BNEL    = 6'd21;
    localparam logic [5:0] OP_BLEZL   = 6'd22;
    localparam logic [5:0] OP_BGTZL   = 6'd23;

    // special function codes
    localparam logic [5:0] FN_JR   = 6'd8;
    localparam logic [5:0] FN_JALR = 6'd9;

    // regimm rt codes
    localparam logic [4:0] RT_BLTZ     = 5'h00;
    localparam logic [4:0] RT_BGEZ     = 5'h01;
    localparam logic [4:0] RT_BLTZL    = 5'h02;
    localparam logic [4:0] RT_BGEZL    = 5'h03;
    localparam logic [4:0] RT_BLTZAL   = 5'h10;
    localparam logic [4:0] RT_BGEZAL   = 5'h11;
    localparam logic [4:0] RT_BLTZALL  = 5'h12;
    localparam logic [4:0] RT_BGEZALL  = 5'h13;
    localparam logic [4:0] RT_BPOSGE32 = 5'h1C;

    // cop1 rs code for branch on condition
    localparam logic [4:0] RS_BC1 = 5'd8;

    localparam logic [4:0] RA_REG = 5'd31;

    // configuration register indexes
    localparam logic [3:0] CFG_DSP_PRESENT = 4'd0;
    localparam logic [3:0] CFG_FPU_PRESENT = 4'd1;

    typedef struct packed {
        logic dsp_present;
        logic fpu_present;
    } cfg_t;

    typedef struct packed {
        logic [31:0] pc;
        logic        in_delay_slot;
        logic [31:0] instr_word;
        logic [31:0] rs_value;
        logic [31:0] rt_value;
        logic [31:0] fp_status;
        logic [5:0]  dsp_pos;
    } item_t;

    typedef struct packed {
        logic [31:0] next_pc;
        logic [2:0]  status;
        logic        link_write;
        logic [4:0]  link_reg;
        logic [31:0] link_value;
    } result_t;

endpackage

[design/brpc_cfg.sv]
// ----------------------------------------------------------------------------
// brpc_cfg: configuration registers
// Holds the DSP and FPU presence flags written through the config channel.
// ----------------------------------------------------------------------------
module brpc_cfg
    import brpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            // unknown indexes are dropped
            if (cfg_index == CFG_DSP_PRESENT) begin
                cfg_next.dsp_present = cfg_data[0];
            end else if (cfg_index == CFG_FPU_PRESENT) begin
                cfg_next.fpu_present = cfg_data[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dsp_present <= 1'b0;
            cfg_reg.fpu_present <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/brpc_decode.sv]
// ----------------------------------------------------------------------------
// brpc_decode: branch decode and target resolution
// Decodes the branch word of a delay-slot fault and forms the resume PC,
// link write and status for one registered item.
// ----------------------------------------------------------------------------
module brpc_decode
    import brpc_pkg::*;
(
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t res
);

    logic [5:0]  op;
    logic [4:0]  rsf;
    logic [4:0]  rtf;
    logic [5:0]  fn;
    logic [31:0] off;
    logic [31:0] pc_plus4;
    logic [31:0] pc_plus8;
    logic [31:0] br_target;
    logic [31:0] jmp_target;
    logic        rs_neg;
    logic        rs_zero;
    logic        rs_eq_rt;
    logic [2:0]  cc;
    logic        cc_set;
    logic        taken;
    logic [31:0] next_pc;
    logic [2:0]  status;
    logic        link_write;
    logic [4:0]  link_reg;

    assign op  = item.instr_word[31:26];
    assign rsf = item.instr_word[25:21];
    assign rtf = item.instr_word[20:16];
    assign fn  = item.instr_word[5:0];

    assign off        = {{14{item.instr_word[15]}}, item.instr_word[15:0], 2'b00};
    assign pc_plus4   = item.pc + 32'd4;
    assign pc_plus8   = item.pc + 32'd8;
    assign br_target  = pc_plus4 + off;
    assign jmp_target = (pc_plus4 & SEG_MASK) | {4'b0000, item.instr_word[25:0], 2'b00};

    assign rs_neg   = item.rs_value[31];
    assign rs_zero  = (item.rs_value == 32'd0);
    assign rs_eq_rt = (item.rs_value == item.rt_value);

    // cc0 sits at bit 23, cc n at bit 24 + n
    assign cc     = rtf[4:2];
    assign cc_set = (cc == 3'd0) ? item.fp_status[23]
                                 : item.fp_status[5'd24 + {2'b00, cc}];

    always_comb begin
        next_pc    = BAD_PC;
        status     = ST_OK;
        link_write = 1'b0;
        link_reg   = 5'd0;
        taken      = 1'b0;
        priority if (!item.in_delay_slot) begin
            next_pc = pc_plus4;
        end else if (item.pc[1:0] != 2'b00) begin
            status = ST_UNALIGNED;
        end else if (item.instr_word == BAD_PC) begin
            status = ST_MARKER;
        end else begin
            unique case (op)
                OP_SPECIAL: begin
                    if (fn == FN_JR || fn == FN_JALR) begin
                        next_pc = item.rs_value;
                        if (fn == FN_JALR) begin
                            link_write = 1'b1;
                            link_reg   = item.instr_word[15:11];
                        end
                    end else begin
                        status = ST_NOT_BR;
                    end
                end
                OP_REGIMM: begin
                    unique case (rtf)
                        RT_BLTZ, RT_BLTZL: taken = rs_neg;
                        RT_BGEZ, RT_BGEZL: taken = !rs_neg;
                        RT_BLTZAL, RT_BLTZALL: begin
                            taken      = rs_neg;
                            link_write = 1'b1;
                            link_reg   = RA_REG;
                        end
                        RT_BGEZAL, RT_BGEZALL: begin
                            taken      = !rs_neg;
                            link_write = 1'b1;
                            link_reg   = RA_REG;
                        end
                        RT_BPOSGE32: begin
                            taken = item.dsp_pos[5];
                            if (!cfg.dsp_present) begin
                                status = ST_NO_UNIT;
                            end
                        end
                        default: status = ST_NOT_BR;
                    endcase
                    next_pc = taken ? br_target : pc_plus8;
                end
                OP_J, OP_JAL: begin
                    next_pc = jmp_target;
                    if (op == OP_JAL) begin
                        link_write = 1'b1;
                        link_reg   = RA_REG;
                    end
                end
                OP_BEQ, OP_BEQL: begin
                    next_pc = rs_eq_rt ? br_target : pc_plus8;
                end
                OP_BNE, OP_BNEL: begin
                    next_pc = !rs_eq_rt ? br_target : pc_plus8;
                end
                OP_BLEZ, OP_BLEZL: begin
                    next_pc = (rs_neg || rs_zero) ? br_target : pc_plus8;
                end
                OP_BGTZ, OP_BGTZL: begin
                    next_pc = (!rs_neg && !rs_zero) ? br_target : pc_plus8;
                end
                OP_COP1: begin
                    if (rsf != RS_BC1) begin
                        status = ST_NOT_BR;
                    end else if (!cfg.fpu_present) begin
                        status = ST_NO_UNIT;
                    end else begin
                        next_pc = (cc_set == rtf[0]) ? br_target : pc_plus8;
                    end
                end
                default: status = ST_NOT_BR;
            endcase
        end
    end

    // errors force the marker PC and drop the link
    always_comb begin
        res.status = status;
        if (status != ST_OK) begin
            res.next_pc    = BAD_PC;
            res.link_write = 1'b0;
            res.link_reg   = 5'd0;
            res.link_value = 32'd0;
        end else begin
            res.next_pc    = next_pc;
            res.link_write = link_write;
            res.link_reg   = link_write ? link_reg : 5'd0;
            res.link_value = link_write ? pc_plus8 : 32'd0;
        end
    end

endmodule

[design/branch_return_pc_resolver_top.sv]
// ----------------------------------------------------------------------------
// branch_return_pc_resolver_top: delay-slot return PC resolver
// Input register, branch decode, result register.
//
//   channel   direction  handshake               payload
//   s_*       in         s_valid / s_ready       pc, in_delay_slot, instr_word,
//                                                rs_value, rt_value, fp_status,
//                                                dsp_pos
//   m_*       out        m_valid / m_ready       next_pc, status, link_write,
//                                                link_reg, link_value
//   cfg_*     in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// An item passes the input register, the decode and the result register; one
// item per cycle is sustained while m_ready is high (single decode stage).
// Reset is synchronous and active low; it empties both stages and loads the
// presence flags (DSP absent, FPU present).
// A stalled result holds the output register; the input register still takes
// a transaction when it is empty, and ready drops only when both are full.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module branch_return_pc_resolver_top
    import brpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_pc,
    input  logic        s_in_delay_slot,
    input  logic [31:0] s_instr_word,
    input  logic [31:0] s_rs_value,
    input  logic [31:0] s_rt_value,
    input  logic [31:0] s_fp_status,
    input  logic [5:0]  s_dsp_pos,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_next_pc,
    output logic [2:0]  m_status,
    output logic        m_link_write,
    output logic [4:0]  m_link_reg,
    output logic [31:0] m_link_value,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    item_t   item_next;
    logic    in_valid_reg;
    logic    in_valid_next;
    result_t res;
    result_t res_reg;
    result_t res_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    out_free;
    logic    advance;
    logic    s_take;

    brpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    brpc_decode u_decode (
        .item (item_reg),
        .cfg  (cfg),
        .res  (res)
    );

    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && out_free;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        item_next      = item_reg;
        in_valid_next  = in_valid_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (out_free) begin
            out_valid_next = in_valid_reg;
            if (advance) begin
                res_next = res;
            end
        end
        if (s_take) begin
            item_next = {s_pc, s_in_delay_slot, s_instr_word, s_rs_value,
                         s_rt_value, s_fp_status, s_dsp_pos};
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
        item_reg <= item_next;
        res_reg  <= res_next;
    end

    assign m_valid      = out_valid_reg;
    assign m_next_pc    = res_reg.next_pc;
    assign m_status     = res_reg.status;
    assign m_link_write = res_reg.link_write;
    assign m_link_reg   = res_reg.link_reg;
    assign m_link_value = res_reg.link_value;

    a_err_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != ST_OK) |-> (m_next_pc == BAD_PC) && !m_link_write)
        else $error("error result carries a PC or link");

    a_nolink_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_link_write |-> (m_link_reg == 5'd0) && (m_link_value == 32'd0))
        else $error("link fields set without link write");

    a_take_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_take |=> in_valid_reg)
        else $error("accepted transaction lost from input stage");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !out_free |=> in_valid_reg && $stable(item_reg))
        else $error("input stage changed while output stalled");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("decoded item did not reach output register");

endmodule
